[rtl/core/srm_pkg.sv]
// Package for the step response metrics block.
// Holds the controller states, the command and status structs and fixed port widths.
// Used by srm_ctrl, srm_dp and step_response_metrics.
package srm_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_PORT_W = 32;
  localparam int unsigned VALUE_PORT_W = 32;
  localparam int unsigned MAG_PORT_W = 31;
  localparam int unsigned RATIO_PORT_W = 32;

  // Configuration register indexes.
  localparam logic CFG_FINAL_VALUE = 1'b0;
  localparam logic CFG_STEP_TIME = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_DIV,
    ST_DONE
  } srm_state_e;

  typedef struct packed {
    logic accept;
    logic finish;
    logic div_step;
    logic publish;
  } srm_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } srm_sts_t;

endpackage

[rtl/core/srm_ctrl.sv]
// Controller of the step response metrics block.
// Sequences sample intake, the end-of-record pass, the ratio division and the result hand-off.
// Depends on srm_pkg.
module srm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_sample_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  srm_pkg::srm_sts_t sts_i,
  output srm_pkg::srm_cmd_t cmd_o
);
  import srm_pkg::*;

  srm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && last_sample_i) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = sts_i.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    cmd_o.accept     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.finish     = (state_q == ST_FINISH);
    cmd_o.div_step   = (state_q == ST_DIV);
    cmd_o.publish    = (state_q == ST_DONE) && slot_free;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // A new result never overwrites one that the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result published over a pending one");

  // The last sample of a record always starts the end-of-record pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_sample_i) |=> (state_q == ST_FINISH))
    else $error("last sample did not start the finish pass");

  // The final division step hands over to the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_last) |=> (state_q == ST_DONE))
    else $error("division did not end in the result stage");
`endif

endmodule

[rtl/core/srm_dp.sv]
// Datapath of the step response metrics block.
// Holds the configuration, the running record state, a bit-serial divider and the result registers.
// Depends on srm_pkg.
module srm_dp #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  srm_pkg::srm_cmd_t                    cmd_i,
  output srm_pkg::srm_sts_t                    sts_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [srm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic [srm_pkg::TIME_PORT_W-1:0]      sample_time_i,
  input  logic signed [srm_pkg::VALUE_PORT_W-1:0] sample_value_i,
  output logic                                 has_data_o,
  output logic [srm_pkg::MAG_PORT_W-1:0]       max_magnitude_o,
  output logic [srm_pkg::RATIO_PORT_W-1:0]     overshoot_ratio_o,
  output logic [31:0]                          final_error_o,
  output logic                                 settled_o,
  output logic [31:0]                          settling_time_o
);
  import srm_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned EW = VW + 1;          // signed difference width
  localparam int unsigned BW = VW + 7;          // room for 50 times a difference
  localparam int unsigned DW = VW + 1 + FRAC_BITS; // dividend bits
  localparam int unsigned CW = $clog2(DW);

  // Configuration.
  logic signed [VW-1:0] fval_q;
  logic [VW-1:0]        fabs_q;
  logic [TW-1:0]        step_q;

  // Record state.
  logic                 seen_q;
  logic [VW-1:0]        mag_q;
  logic signed [VW-1:0] peak_q;
  logic signed [VW-1:0] last_q;
  logic [TW-1:0]        entry_q;
  logic                 run_q;

  // Divider.
  logic [VW-1:0]        rem_q;
  logic [DW-1:0]        dvd_q;
  logic [31:0]          quo_q;
  logic                 ovf_q;
  logic [CW-1:0]        cnt_q;

  // Held results.
  logic                 res_has_q;
  logic [30:0]          res_mag_q;
  logic [31:0]          res_err_q;
  logic                 res_set_q;
  logic [31:0]          res_time_q;

  // Output registers.
  logic                 out_has_q;
  logic [30:0]          out_mag_q;
  logic [31:0]          out_ratio_q;
  logic [31:0]          out_err_q;
  logic                 out_set_q;
  logic [31:0]          out_time_q;

  logic [63:0]          wdata_ext, time_ext, value_ext;
  logic signed [VW-1:0] cfg_val, x;
  logic [VW-1:0]        cfg_abs, x_abs;
  logic [TW-1:0]        cfg_time, t;
  logic [EW-1:0]        d_raw, d_abs, e_raw, e_abs, num;
  logic [BW-1:0]        d_wide, band_prod;
  logic                 in_band, t_ge, take;
  logic [63:0]          mag_ext, err_ext, entry_ext;
  logic [VW-1:0]        rem_sh;
  logic                 qbit;

  // Inputs wider than the working width are cut; narrower ones are zero-extended first.
  assign wdata_ext = 64'(cfg_wdata_i);
  assign time_ext  = 64'(sample_time_i);
  assign value_ext = 64'($unsigned(sample_value_i));
  assign cfg_val   = wdata_ext[VW-1:0];
  assign cfg_time  = wdata_ext[TW-1:0];
  assign x         = value_ext[VW-1:0];
  assign t         = time_ext[TW-1:0];

  assign cfg_abs = cfg_val[VW-1] ? ((~cfg_val) + VW'(1)) : cfg_val;
  assign x_abs   = x[VW-1] ? ((~x) + VW'(1)) : x;

  // Band test: 50 * |x - F| <= |F|.
  assign d_raw     = {x[VW-1], x} - {fval_q[VW-1], fval_q};
  assign d_abs     = d_raw[EW-1] ? ((~d_raw) + EW'(1)) : d_raw;
  assign d_wide    = BW'(d_abs);
  assign band_prod = (d_wide << 5) + (d_wide << 4) + (d_wide << 1);
  assign in_band   = band_prod <= BW'(fabs_q);

  assign t_ge = t >= step_q;
  assign take = seen_q || t_ge;

  // End-of-record values.
  assign e_raw     = {last_q[VW-1], last_q} - {fval_q[VW-1], fval_q};
  assign e_abs     = e_raw[EW-1] ? ((~e_raw) + EW'(1)) : e_raw;
  assign num       = {peak_q[VW-1], peak_q} - {fval_q[VW-1], fval_q};
  assign mag_ext   = 64'(mag_q);
  assign err_ext   = 64'(e_abs);
  assign entry_ext = 64'(entry_q);

  assign sts_o.need_div = seen_q && (fval_q != '0) && (peak_q > fval_q);
  assign sts_o.div_last = (cnt_q == '0);

  // One restoring step per cycle; the remainder stays below |F|.
  assign rem_sh = {rem_q[VW-2:0], dvd_q[DW-1]};
  assign qbit   = rem_sh >= fabs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fval_q  <= '0;
      fabs_q  <= '0;
      step_q  <= '0;
      seen_q  <= 1'b0;
      mag_q   <= '0;
      peak_q  <= '0;
      last_q  <= '0;
      entry_q <= '0;
      run_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FINAL_VALUE: begin
            fval_q <= cfg_val;
            fabs_q <= cfg_abs;
          end
          CFG_STEP_TIME: step_q <= cfg_time;
          default: ;
        endcase
      end
      if (cmd_i.accept && take) begin
        seen_q <= 1'b1;
        if (x_abs > mag_q) begin
          mag_q <= x_abs;
        end
        // The first counted sample seeds the peak.
        if (!seen_q || (x > peak_q)) begin
          peak_q <= x;
        end
        last_q <= x;
        if (!in_band) begin
          run_q <= 1'b0;
        end else if (!run_q) begin
          run_q   <= 1'b1;
          entry_q <= t;
        end
      end
      if (cmd_i.finish) begin
        seen_q  <= 1'b0;
        mag_q   <= '0;
        peak_q  <= '0;
        last_q  <= '0;
        entry_q <= '0;
        run_q   <= 1'b0;
        cnt_q   <= CW'(DW - 1);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_has_q  <= seen_q;
      res_mag_q  <= (mag_ext > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : mag_ext[30:0];
      res_err_q  <= !seen_q ? 32'h0 :
                    (err_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : err_ext[31:0];
      res_set_q  <= run_q;
      res_time_q <= run_q ? entry_ext[31:0] : 32'h0;
      rem_q      <= '0;
      dvd_q      <= DW'(num) << FRAC_BITS;
      quo_q      <= '0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? (rem_sh - fabs_q) : rem_sh;
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[30:0], qbit};
      ovf_q <= ovf_q | quo_q[31];
    end
    if (cmd_i.publish) begin
      out_has_q   <= res_has_q;
      out_mag_q   <= res_mag_q;
      out_ratio_q <= ovf_q ? 32'hFFFF_FFFF : quo_q;
      out_err_q   <= res_err_q;
      out_set_q   <= res_set_q;
      out_time_q  <= res_time_q;
    end
  end

  assign has_data_o        = out_has_q;
  assign max_magnitude_o   = out_mag_q;
  assign overshoot_ratio_o = out_ratio_q;
  assign final_error_o     = out_err_q;
  assign settled_o         = out_set_q;
  assign settling_time_o   = out_time_q;

endmodule

[rtl/core/step_response_metrics.sv]
// Step response metrics: one running pass over a sampled record, one result per record.
// Channels: sample requests in (valid/ready), one metrics request out per record
// (valid/ready), and a plain write port for final_value (index 0) and step_time (index 1).
// Samples are taken one per cycle while no record is being closed. Samples before the
// first one at or after step_time are ignored. The request that carries last_sample
// closes the record: once that request is accepted, the block runs the end-of-record
// pass, then the ratio division when an overshoot ratio has to be divided out, and
// then publishes the result to the output register. The bit-serial divider makes one
// quotient bit per cycle; no sample is taken while it runs.
// The result sits in an output register, so samples of the next record keep flowing
// while it waits; if the receiver still stalls when the next record closes, the block
// holds that record's result and accepts no sample until the pending one is taken.
// Reset clears the configuration to zero, empties the record and drops any result.
// Values are signed Q16.16; ratio and errors saturate at their field widths.
module step_response_metrics #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic                                    cfg_idx_i,
  input  logic [srm_pkg::CFG_DATA_W-1:0]          cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [srm_pkg::TIME_PORT_W-1:0]         sample_time_i,
  input  logic signed [srm_pkg::VALUE_PORT_W-1:0] sample_value_i,
  input  logic                                    last_sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    has_data_o,
  output logic [srm_pkg::MAG_PORT_W-1:0]          max_magnitude_o,
  output logic [srm_pkg::RATIO_PORT_W-1:0]        overshoot_ratio_o,
  output logic [31:0]                             final_error_o,
  output logic                                    settled_o,
  output logic [31:0]                             settling_time_o
);
  import srm_pkg::*;

  srm_cmd_t cmd;
  srm_sts_t sts;

  srm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_sample_i(last_sample_i),
    .in_ready_o   (in_ready_o),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  srm_dp #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_time_i    (sample_time_i),
    .sample_value_i   (sample_value_i),
    .has_data_o       (has_data_o),
    .max_magnitude_o  (max_magnitude_o),
    .overshoot_ratio_o(overshoot_ratio_o),
    .final_error_o    (final_error_o),
    .settled_o        (settled_o),
    .settling_time_o  (settling_time_o)
  );

endmodule

[bench/tb_step_response_metrics.sv]
`timescale 1ns / 1ps
// Testbench for step_response_metrics: directed and random sample records are
// checked against an in-bench predictor of the per-record metrics.
// Depends on srm_pkg and the step_response_metrics RTL.
module tb_step_response_metrics;
  import srm_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam longint      VALUE_MAX     = 64'sd2147483647;
  localparam longint      VALUE_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic        has_data;
    logic [30:0] max_magnitude;
    logic [31:0] overshoot_ratio;
    logic [31:0] final_error;
    logic        settled;
    logic [31:0] settling_time;
  } metrics_t;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          cfg_we       = 1'b0;
  logic                          cfg_idx      = CFG_FINAL_VALUE;
  logic [CFG_DATA_W-1:0]         cfg_wdata    = '0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic [TIME_PORT_W-1:0]        sample_time  = '0;
  logic signed [VALUE_PORT_W-1:0] sample_value = '0;
  logic                          last_sample  = 1'b0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic                          has_data;
  logic [MAG_PORT_W-1:0]         max_magnitude;
  logic [RATIO_PORT_W-1:0]       overshoot_ratio;
  logic [31:0]                   final_error;
  logic                          settled;
  logic [31:0]                   settling_time;

  // Predictor copy of the configuration and of the running record.
  longint      final_target = 0;
  logic [31:0] step_start   = '0;
  logic        rec_seen     = 1'b0;
  logic [63:0] rec_mag      = '0;
  longint      rec_peak     = 0;
  longint      rec_last     = 0;
  logic [31:0] rec_entry    = '0;
  logic        rec_in_band  = 1'b0;

  metrics_t    metrics_q[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned rx_hold     = 0;
  bit          idle_en     = 1'b1;

  step_response_metrics u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .sample_time_i    (sample_time),
    .sample_value_i   (sample_value),
    .last_sample_i    (last_sample),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .has_data_o       (has_data),
    .max_magnitude_o  (max_magnitude),
    .overshoot_ratio_o(overshoot_ratio),
    .final_error_o    (final_error),
    .settled_o        (settled),
    .settling_time_o  (settling_time)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] abs_dist(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Exact 2% band: 50 * |x - F| <= |F|.
  function automatic logic within_band(input longint x);
    return abs_dist(x, final_target) * 64'd50 <= abs_dist(final_target, 0);
  endfunction

  function automatic logic [31:0] overshoot_q(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    if (num / den >= 64'd65536) return 32'hFFFF_FFFF;
    q = (num << 16) / den;
    return q[31:0];
  endfunction

  function automatic void clear_record();
    rec_seen    = 1'b0;
    rec_mag     = '0;
    rec_peak    = 0;
    rec_last    = 0;
    rec_entry   = '0;
    rec_in_band = 1'b0;
  endfunction

  function automatic void predict_sample(input logic [31:0] t, input logic signed [31:0] v,
                                         input logic last);
    longint      x;
    metrics_t    m;
    logic [63:0] err;
    x = v;
    if (!rec_seen && t >= step_start) begin
      rec_seen = 1'b1;
      rec_peak = x;
    end
    if (rec_seen) begin
      if (abs_dist(x, 0) > rec_mag) rec_mag = abs_dist(x, 0);
      if (x > rec_peak) rec_peak = x;
      rec_last = x;
      if (!within_band(x)) begin
        rec_in_band = 1'b0;
      end else if (!rec_in_band) begin
        rec_in_band = 1'b1;
        rec_entry   = t;
      end
    end
    if (last) begin
      m = '0;
      if (rec_seen) begin
        m.has_data      = 1'b1;
        m.max_magnitude = (rec_mag > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : rec_mag[30:0];
        if (final_target != 0 && rec_peak > final_target)
          m.overshoot_ratio = overshoot_q(abs_dist(rec_peak, final_target),
                                          abs_dist(final_target, 0));
        err             = abs_dist(rec_last, final_target);
        m.final_error   = (err > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : err[31:0];
        m.settled       = rec_in_band;
        m.settling_time = rec_in_band ? rec_entry : 32'h0;
      end
      metrics_q.push_back(m);
      clear_record();
    end
  endfunction

  task automatic send_sample(input logic [31:0] t, input logic [31:0] v, input logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    sample_time  <= t;
    sample_value <= v;
    last_sample  <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
    predict_sample(t, v, last);
  endtask

  // Hold off new requests until every expected result has been taken, then let
  // the block finish any work that produces no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (metrics_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [31:0] final_val, input logic [31:0] step_val);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FINAL_VALUE;
    cfg_wdata <= final_val;
    @(posedge clk_i);
    cfg_idx   <= CFG_STEP_TIME;
    cfg_wdata <= step_val;
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    final_target = $signed(final_val);
    step_start   = step_val;
  endtask

  // A well-formed record starts just before the step, rings around the final value
  // and mostly settles into the band; a noisy one has random times and values.
  task automatic send_record(input bit noisy);
    int unsigned len;
    logic [31:0] t;
    longint      span, amp, v;
    len  = noisy ? $urandom_range(1, 8) : $urandom_range(1, 16);
    t    = step_start - $urandom_range(0, 3);
    span = abs_dist(final_target, 0);
    for (int unsigned i = 0; i < len; i++) begin
      if (noisy) begin
        send_sample($urandom, $urandom, i == len - 1);
      end else begin
        if (i < len / 2) amp = span / 4 + 1;
        else if ($urandom_range(0, 4) == 0) amp = span / 10 + 1;
        else amp = span / 60;
        v = final_target + longint'($urandom_range(0, 2 * amp)) - amp;
        if (v > VALUE_MAX) v = VALUE_MAX;
        if (v < VALUE_MIN) v = VALUE_MIN;
        send_sample(t, v[31:0], i == len - 1);
        if ($urandom_range(0, 9) == 0) t = t - $urandom_range(1, 8);
        else t = t + $urandom_range(1, 4);
      end
    end
  endtask

  task automatic test_reset_defaults();
    // Final value zero after reset: only an exact zero is in band, no overshoot.
    send_sample(32'd10, 32'd0, 1'b0);
    send_sample(32'd11, 32'd5, 1'b0);
    send_sample(32'd12, 32'd0, 1'b0);
    send_sample(32'd13, 32'd0, 1'b1);
  endtask

  task automatic test_skipped_samples();
    apply_config(32'h0001_0000, 32'd1000);
    // A record that ends before the step gives an all-zero result.
    send_sample(32'd5, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'd999, 32'hFFFF_FFFB, 1'b1);
    // Once counting has begun, an earlier time stamp still counts.
    send_sample(32'd1000, 32'h0001_8000, 1'b0);
    send_sample(32'd20, 32'h0000_F000, 1'b0);
    send_sample(32'd1001, 32'h0001_0100, 1'b1);
    // Peak below the final value gives no overshoot.
    send_sample(32'd1000, 32'h0000_8000, 1'b0);
    send_sample(32'd1002, 32'h0000_FF00, 1'b1);
  endtask

  task automatic test_basic_step();
    apply_config(32'h0002_0000, 32'd100);
    send_sample(32'd98, 32'h0000_0000, 1'b0);
    send_sample(32'd100, 32'h0000_4000, 1'b0);
    send_sample(32'd104, 32'h0002_8000, 1'b0);
    send_sample(32'd108, 32'h0001_F000, 1'b0);
    send_sample(32'd112, 32'h0002_0100, 1'b0);
    send_sample(32'd116, 32'h0001_FF00, 1'b0);
    send_sample(32'd120, 32'h0002_0000, 1'b1);
    // Ends outside the band: not settled.
    send_sample(32'd100, 32'h0002_0000, 1'b0);
    send_sample(32'd101, 32'h0003_0000, 1'b1);
  endtask

  task automatic test_extremes();
    apply_config(32'h8000_0000, 32'd0);
    send_sample(32'd0, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    // Tiny final value makes the ratio saturate.
    apply_config(32'h0000_0001, 32'd0);
    send_sample(32'd7, 32'h7FFF_FFFF, 1'b1);
    apply_config(32'h7FFF_FFFF, 32'd0);
    send_sample(32'd7, 32'h8000_0000, 1'b0);
    send_sample(32'd8, 32'h7FFF_FFFF, 1'b1);
    send_sample(32'd9, 32'h8000_0000, 1'b1);
  endtask

  task automatic test_step_time_max();
    apply_config(32'h0001_0000, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFE, 32'h0004_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
  endtask

  task automatic test_random_records();
    logic [31:0] fv, sv;
    int unsigned goal;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       fv = 32'h0001_0000;
        1:       fv = 32'h8000_0000;
        2:       fv = 32'h7FFF_FFFF;
        3:       fv = 32'h0000_0000;
        4:       fv = 32'h0000_0001;
        5:       fv = 32'hFFFD_0000;
        default: fv = $urandom;
      endcase
      if (phase % 3 == 0) sv = 32'd0;
      else if (phase == 4) sv = 32'hFFFF_FFFF;
      else sv = $urandom;
      apply_config(fv, sv);
      idle_en = (phase != 6);
      goal    = items_sent + 115;
      while (items_sent < goal) begin
        send_record($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 11) == 0) drain();
      end
    end
  endtask

  task automatic test_back_to_back();
    int unsigned goal;
    apply_config($urandom_range(32'h0000_1000, 32'h0100_0000), 32'd50);
    idle_en = 1'b0;
    goal    = items_sent + 150;
    while (items_sent < goal) send_record($urandom_range(0, 7) == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_skipped_samples();
    test_basic_step();
    test_extremes();
    test_step_time_max();
    test_random_records();
    test_back_to_back();
    drain();
    if (fail_count == 0) $display("tb_step_response_metrics: PASS");
    else $display("tb_step_response_metrics: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rx_hold != 0) rx_hold = rx_hold - 1;
    else if (idle_en && $urandom_range(0, 4) == 0) rx_hold = $urandom_range(1, 5);
    out_ready <= (rx_hold == 0);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("mismatch in %s: expected 0x%08h, got 0x%08h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    metrics_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (metrics_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("metrics request with none expected: max_magnitude 0x%08h", max_magnitude);
      end else begin
        want = metrics_q.pop_front();
        check_field("has_data", want.has_data, has_data);
        check_field("max_magnitude", want.max_magnitude, max_magnitude);
        check_field("overshoot_ratio", want.overshoot_ratio, overshoot_ratio);
        check_field("final_error", want.final_error, final_error);
        check_field("settled", want.settled, settled);
        check_field("settling_time", want.settling_time, settling_time);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_step_response_metrics: FAIL");
      $finish;
    end
  end

endmodule

[files.f]
rtl/core/srm_pkg.sv
rtl/core/srm_ctrl.sv
rtl/core/srm_dp.sv
rtl/core/step_response_metrics.sv
bench/tb_step_response_metrics.sv
